// File: sv/fcst_pkg.sv
package fcst_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W   = 8;
  localparam int POS_W   = 10;
  localparam int THR_W   = 8;
  localparam int SER_W   = 5;
  localparam int SIZE_W  = 11;
  localparam int CIRC_N  = 16;
  localparam int WIN_N   = 7;
  localparam int LINES   = 6;
  localparam int RADIUS  = 3;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd10;
  localparam logic [SER_W-1:0]  SERIES_RST    = 5'd12;
  localparam logic [SIZE_W-1:0] WIDTH_RST     = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST    = 11'd480;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SERIES    = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // Window row and column of each point of the radius-3 circle, clockwise from the top.
  localparam int CIRC_ROW [CIRC_N] = '{0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0};
  localparam int CIRC_COL [CIRC_N] = '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};

  function automatic logic [CIRC_N-1:0] rotl16(input logic [CIRC_N-1:0] v, input int n);
    logic [2*CIRC_N-1:0] d;
    d = {v, v} << n;
    return d[2*CIRC_N-1:CIRC_N];
  endfunction

endpackage

// File: sv/fcst_in_if.sv
interface fcst_in_if;
  import fcst_pkg::*;
  logic       valid;
  logic       ready;
  pix_t       pixel;
  logic       frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// File: sv/fcst_out_if.sv
interface fcst_out_if;
  import fcst_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic             is_corner;
  modport source (output valid, output row, output col, output is_corner, input ready);
  modport sink   (input valid, input row, input col, input is_corner, output ready);
endinterface

// File: sv/fast_corner_segment_test_unit.sv
// Channel  Dir  Handshake      Word
// in_ch    in   valid / ready  pixel, frame_start (raster order)
// out_ch   out  valid / ready  row, col, is_corner (one per interior centre)
// cfg      in   APB, pready=1  threshold, series_length, image_width, image_height
//
// One pixel is accepted every cycle while the pipeline advances; the line store RAM is read at
// acceptance and written back from the s1 registers, so the column read-modify-write sets the rate.
// A result passes the s1, s2, s3 and output registers after its pixel is accepted.
// Reset (synchronous, rst_n low) clears counters, window and pipeline; the line
// store is not cleared and no clearing pass is needed.
// The pipeline stalls only when a result is waiting and out_ch.ready is low.
module fast_corner_segment_test_unit #(
  parameter int MAX_WIDTH  = fcst_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fcst_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fcst_in_if.sink                     in_ch,
  fcst_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcst_pkg::CFG_AW-1:0] paddr,
  input  logic [fcst_pkg::CFG_DW-1:0] pwdata,
  output logic [fcst_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import fcst_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int MXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW  = $clog2(MXD) + 2;
  localparam int WW  = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int LW  = LINES * PIX_W;

  // Configuration
  logic [THR_W-1:0]  threshold_r;
  logic [SER_W-1:0]  series_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      series_r    <= SERIES_RST;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD: threshold_r <= pwdata[THR_W-1:0];
        REG_SERIES:    series_r    <= pwdata[SER_W-1:0];
        REG_WIDTH:     width_r     <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:    height_r    <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_THRESHOLD: prdata[THR_W-1:0]  = threshold_r;
      REG_SERIES:    prdata[SER_W-1:0]  = series_r;
      REG_WIDTH:     prdata[SIZE_W-1:0] = width_r;
      REG_HEIGHT:    prdata[SIZE_W-1:0] = height_r;
      default:       prdata = '0;
    endcase
  end

  // Effective frame size
  logic [WW-1:0] w_ext, h_ext, w_eff, h_eff;
  assign w_ext = WW'(width_r);
  assign h_ext = WW'(height_r);
  always_comb begin
    w_eff = (w_ext == '0) ? WW'(1) : w_ext;
    if (w_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    h_eff = (h_ext == '0) ? WW'(1) : h_ext;
    if (h_ext > WW'(MAX_HEIGHT)) h_eff = WW'(MAX_HEIGHT);
  end

  // Pipeline control
  logic adv, accept;
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_emit_r, s2_emit_r, s3_emit_r;

  assign adv          = !out_valid_r || out_ch.ready || !(s3_valid_r && s3_emit_r);
  assign in_ch.ready  = adv;
  assign accept       = in_ch.valid && adv;

  // Position counters
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [2:0]    rm_r, rm_nxt;
  logic [CW-1:0] c0, r0;
  logic [2:0]    rm0;

  always_comb begin
    c0  = in_ch.frame_start ? '0 : col_r;
    r0  = in_ch.frame_start ? '0 : row_r;
    rm0 = in_ch.frame_start ? '0 : rm_r;
    if (WW'(c0) >= w_eff) begin
      c0  = '0;
      r0  = r0 + CW'(1);
      rm0 = (rm0 == 3'(LINES - 1)) ? '0 : rm0 + 3'd1;
    end
    if (WW'(r0) >= h_eff) begin
      r0  = '0;
      rm0 = '0;
    end
    if (WW'(c0) + WW'(1) >= w_eff) begin
      col_nxt = '0;
      if (WW'(r0) + WW'(1) >= h_eff) begin
        row_nxt = '0;
        rm_nxt  = '0;
      end else begin
        row_nxt = r0 + CW'(1);
        rm_nxt  = (rm0 == 3'(LINES - 1)) ? '0 : rm0 + 3'd1;
      end
    end else begin
      col_nxt = c0 + CW'(1);
      row_nxt = r0;
      rm_nxt  = rm0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rm_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      rm_r  <= rm_nxt;
    end
  end

  // Line store: one word per column holding all six stored lines
  logic [LW-1:0] rd_word, word, wr_word, fwd_word_r;
  logic          fwd_r;
  pix_t          s1_pix_r;
  logic [CW-1:0] s1_col_r, s1_row_r, s2_col_r, s2_row_r, s3_col_r, s3_row_r;
  logic [2:0]    s1_rm_r;

  fcst_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .we      (s1_valid_r && adv),
    .waddr   (s1_col_r[AW-1:0]),
    .wdata   (wr_word),
    .re      (accept),
    .raddr   (c0[AW-1:0]),
    .rdata_r (rd_word)
  );

  // A write landing on the edge of a read to the same column is forwarded.
  assign word = fwd_r ? fwd_word_r : rd_word;
  always_comb begin
    wr_word = word;
    wr_word[s1_rm_r*PIX_W +: PIX_W] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
      fwd_r      <= accept && s1_valid_r && (s1_col_r == c0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_word_r <= wr_word;
      s1_pix_r   <= in_ch.pixel;
      s1_col_r   <= c0;
      s1_row_r   <= r0;
      s1_rm_r    <= rm0;
      s1_emit_r  <= (WW'(r0) >= WW'(LINES)) && (WW'(c0) >= WW'(LINES));
    end
  end

  // 7x7 window
  pix_t win_r [WIN_N][WIN_N];
  pix_t new_col [WIN_N];
  logic [3:0] slot;

  always_comb begin
    for (int y = 0; y < LINES; y++) begin
      slot = 4'(s1_rm_r) + 4'(y);
      if (slot >= 4'(LINES)) slot = slot - 4'(LINES);
      new_col[y] = word[slot*PIX_W +: PIX_W];
    end
    new_col[WIN_N-1] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int y = 0; y < WIN_N; y++)
        for (int x = 0; x < WIN_N; x++)
          win_r[y][x] <= '0;
    end else if (adv && s1_valid_r) begin
      for (int y = 0; y < WIN_N; y++) begin
        for (int x = 0; x < WIN_N - 1; x++)
          win_r[y][x] <= win_r[y][x+1];
        win_r[y][WIN_N-1] <= new_col[y];
      end
    end
  end

  // Classification of the circle against the centre
  logic [CIRC_N-1:0] bright, dark, bright_r, dark_r;
  always_comb begin
    for (int k = 0; k < CIRC_N; k++) begin
      bright[k] = 10'(win_r[CIRC_ROW[k]][CIRC_COL[k]]) >
                  10'(win_r[RADIUS][RADIUS]) + 10'(threshold_r);
      dark[k]   = 10'(win_r[RADIUS][RADIUS]) >
                  10'(win_r[CIRC_ROW[k]][CIRC_COL[k]]) + 10'(threshold_r);
      if (bright[k]) dark[k] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_emit_r <= s1_emit_r;
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
      s3_emit_r <= s2_emit_r;
      s3_col_r  <= s2_col_r;
      s3_row_r  <= s2_row_r;
      bright_r  <= bright;
      dark_r    <= dark;
    end
  end

  // Contiguous arc search over all sixteen starting points
  logic [SER_W-1:0]  len;
  logic [CIRC_N-1:0] arc, m;
  logic              corner;
  always_comb begin
    len = (series_r > SER_W'(CIRC_N)) ? SER_W'(CIRC_N) : series_r;
    arc = (len == SER_W'(CIRC_N)) ? '1 : CIRC_N'((32'd1 << len) - 32'd1);
    corner = (len == '0);
    for (int n = 0; n < CIRC_N; n++) begin
      m = rotl16(arc, n);
      if ((bright_r & m) == m || (dark_r & m) == m) corner = 1'b1;
    end
  end

  logic [POS_W-1:0] out_row_r, out_col_r;
  logic             out_corner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s3_valid_r && s3_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid_r && s3_emit_r) begin
      out_row_r    <= POS_W'(s3_row_r - CW'(RADIUS));
      out_col_r    <= POS_W'(s3_col_r - CW'(RADIUS));
      out_corner_r <= corner;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row       = out_row_r;
  assign out_ch.col       = out_col_r;
  assign out_ch.is_corner = out_corner_r;

endmodule

// File: sv/fcst_ram.sv
module fcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule

// File: sv/fcst_checker.sv
module fcst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_row,
  input logic [9:0] out_col,
  input logic       out_corner
);
  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown straight after reset");

  a_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row >= 10'd3 && out_col >= 10'd3))
    else $error("result word for a centre too close to the border");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) && $stable(out_corner))
    else $error("result word changed while stalled");
endmodule

bind fast_corner_segment_test_unit fcst_checker u_fcst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_row    (out_ch.row),
  .out_col    (out_ch.col),
  .out_corner (out_ch.is_corner)
);
